### sv/wfq_pkg.sv
// types and constants for the window fault qualifier
// no dependencies; imported by window_fault_qualifier
`default_nettype none

package wfq_pkg;

    typedef enum logic [1:0] {
        ST_NORMAL = 2'd0,
        ST_UNDER  = 2'd1,
        ST_OVER   = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        CFG_LOWER_TRIP    = 3'd0,
        CFG_UPPER_TRIP    = 3'd1,
        CFG_LOWER_RECOVER = 3'd2,
        CFG_UPPER_RECOVER = 3'd3,
        CFG_PERSIST_COUNT = 3'd4,
        CFG_TRIP_LIMIT    = 3'd5,
        CFG_CURRENT_MODE  = 3'd6
    } cfg_index_t;

    localparam int CHAN_W   = 4;
    localparam int CFG_W    = 16;
    localparam int THR_W    = 16;
    localparam int CNT_W    = 16;
    localparam int EVT_W    = 8;
    localparam int OUT_W    = 8;
    localparam logic [EVT_W-1:0] EVENT_MAX = 8'd255;

    // per-channel state word held in memory
    typedef struct packed {
        logic              seen;
        logic [EVT_W-1:0]  events;
        logic [CNT_W-1:0]  above_cnt;
        logic [CNT_W-1:0]  under_cnt;
        logic [1:0]        status;
    } chan_state_t;

    localparam int STATE_W = $bits(chan_state_t);

endpackage

`default_nettype wire

### sv/window_fault_qualifier.sv
// per-channel window comparator with recovery hysteresis and persistence debounce
// channel state in one synchronous memory; depends on wfq_pkg
//
//  channel | dir | tdata fields (lsb first)      | notes
//  s_axis  | in  | channel[3:0], sample[SW-1:0]  | one item per sample
//  m_axis  | out | chan_out[3:0], status[1:0],   | one item per input item
//          |     | latched[0]                    |
//  cfg     | in  | cfg_index selects register    | write only, no wait
//
// one item per cycle sustained while the output is taken; an accepted item
// passes the update stage, then its result enters the output register (memory
// read, then update and write back); a back-to-back item on the same channel
// takes the written state through a forwarding register
// synchronous active-low reset loads config defaults, clears pipeline and
// per-entry valid bits; entries not yet written read as normal with zero counters
// input stalls only when the output register is full and not being taken
`default_nettype none

module window_fault_qualifier #(
    parameter int CHANNELS     = 16,
    parameter int SAMPLE_WIDTH = 16
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // channel[3:0], sample[SAMPLE_WIDTH+3:4]
    input  wire logic [((wfq_pkg::CHAN_W+SAMPLE_WIDTH+7)/8)*8-1:0] s_tdata,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // chan_out[3:0], status[5:4], latched[6]
    output logic [wfq_pkg::OUT_W-1:0]  m_tdata,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    input  wire logic                  cfg_we,
    input  wire logic [2:0]            cfg_index,
    input  wire logic [wfq_pkg::CFG_W-1:0] cfg_wdata
);
    import wfq_pkg::*;

    localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CW = (AW > CHAN_W) ? AW : CHAN_W;
    localparam int CMP_W = ((SAMPLE_WIDTH > THR_W) ? SAMPLE_WIDTH : THR_W) + 1;

    // configuration
    logic signed [THR_W-1:0] lower_trip_reg, upper_trip_reg;
    logic signed [THR_W-1:0] lower_recover_reg, upper_recover_reg;
    logic [CNT_W-1:0]        persist_count_reg;
    logic [EVT_W-1:0]        trip_limit_reg;
    logic                    current_mode_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lower_trip_reg    <= 16'sh8000;
            upper_trip_reg    <= 16'sh7fff;
            lower_recover_reg <= 16'sh8000;
            upper_recover_reg <= 16'sh7fff;
            persist_count_reg <= 16'd10;
            trip_limit_reg    <= 8'd3;
            current_mode_reg  <= 1'b0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_LOWER_TRIP:    lower_trip_reg    <= cfg_wdata;
                CFG_UPPER_TRIP:    upper_trip_reg    <= cfg_wdata;
                CFG_LOWER_RECOVER: lower_recover_reg <= cfg_wdata;
                CFG_UPPER_RECOVER: upper_recover_reg <= cfg_wdata;
                CFG_PERSIST_COUNT: persist_count_reg <= cfg_wdata;
                CFG_TRIP_LIMIT:    trip_limit_reg    <= cfg_wdata[EVT_W-1:0];
                CFG_CURRENT_MODE:  current_mode_reg  <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // input decode
    logic [CHAN_W-1:0]              s_chan;
    logic signed [SAMPLE_WIDTH-1:0] s_sample;
    logic [CW-1:0]                  s_chan_ext;
    logic [AW-1:0]                  s_addr;
    logic                           s_inrange;
    logic                           s_accept;

    assign s_chan     = s_tdata[CHAN_W-1:0];
    assign s_sample   = s_tdata[CHAN_W +: SAMPLE_WIDTH];
    assign s_chan_ext = CW'(s_chan);
    assign s_addr     = s_chan_ext[AW-1:0];
    assign s_inrange  = (32'(s_chan) < 32'(CHANNELS));
    assign s_accept   = s_tvalid && s_tready;

    // update stage
    logic                           s1_valid_reg;
    logic [CHAN_W-1:0]              s1_chan_reg;
    logic signed [SAMPLE_WIDTH-1:0] s1_sample_reg;
    logic [AW-1:0]                  s1_addr_reg;
    logic                           s1_inrange_reg;
    logic                           s1_adv;

    // output register
    logic                           m_valid_reg;
    logic [OUT_W-1:0]               m_data_reg;

    // state memory
    chan_state_t                    mem [CHANNELS];
    chan_state_t                    rd_data_reg;
    logic                           rd_vld_reg;
    logic [CHANNELS-1:0]            vld_reg;
    logic                           fwd_reg;
    chan_state_t                    fwd_data_reg;
    logic                           mem_we;

    chan_state_t                    cur;
    chan_state_t                    upd;
    status_t                        st;
    logic                           lat;

    assign s1_adv   = s1_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !s1_valid_reg || s1_adv;
    assign mem_we   = s1_adv && s1_inrange_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            fwd_reg      <= 1'b0;
        end else begin
            if (s_accept) begin
                s1_valid_reg <= 1'b1;
                fwd_reg      <= mem_we && (s1_addr_reg == s_addr);
            end else if (s1_adv) begin
                s1_valid_reg <= 1'b0;
                fwd_reg      <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_chan_reg    <= s_chan;
            s1_sample_reg  <= s_sample;
            s1_addr_reg    <= s_addr;
            s1_inrange_reg <= s_inrange;
            fwd_data_reg   <= upd;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            rd_data_reg <= mem[s_addr];
        end
        if (mem_we) begin
            mem[s1_addr_reg] <= upd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end else begin
            if (s_accept) begin
                rd_vld_reg <= vld_reg[s_addr];
            end
            if (mem_we) begin
                vld_reg[s1_addr_reg] <= 1'b1;
            end
        end
    end

    // window compares
    logic signed [CMP_W-1:0] smp_x;
    logic signed [CMP_W-1:0] lt_x, ut_x, lr_x, ur_x;
    logic                    bel_trip, abv_trip, bel_rec, abv_rec;
    logic                    under_hit, over_hit;

    assign smp_x    = CMP_W'(s1_sample_reg);
    assign lt_x     = CMP_W'(lower_trip_reg);
    assign ut_x     = CMP_W'(upper_trip_reg);
    assign lr_x     = CMP_W'(lower_recover_reg);
    assign ur_x     = CMP_W'(upper_recover_reg);
    assign bel_trip = smp_x < lt_x;
    assign abv_trip = smp_x > ut_x;
    assign bel_rec  = smp_x < lr_x;
    assign abv_rec  = smp_x > ur_x;

    always_comb begin
        priority if (fwd_reg) begin
            cur = fwd_data_reg;
        end else if (rd_vld_reg) begin
            cur = rd_data_reg;
        end else begin
            cur = '0;
        end
    end

    // persistence: limit already reached
    assign under_hit = !(cur.under_cnt < persist_count_reg);
    assign over_hit  = !(cur.above_cnt < persist_count_reg);

    always_comb begin
        logic [CNT_W-1:0] under_inc;
        logic [CNT_W-1:0] over_inc;
        logic             do_normal;
        logic             do_under;
        logic             do_over;
        under_inc = under_hit ? cur.under_cnt : cur.under_cnt + 1'b1;
        over_inc  = over_hit ? cur.above_cnt : cur.above_cnt + 1'b1;
        upd       = cur;
        st        = ST_NORMAL;
        lat       = 1'b0;
        do_normal = 1'b0;
        do_under  = 1'b0;
        do_over   = 1'b0;

        if (current_mode_reg) begin
            if (cur.events >= trip_limit_reg) begin
                st  = ST_OVER;
                lat = 1'b1;
            end else begin
                unique case (cur.status)
                    ST_NORMAL: begin
                        do_normal = 1'b1;
                        upd.seen  = 1'b0;
                    end
                    ST_OVER: begin
                        do_over = 1'b1;
                        if (!cur.seen) begin
                            if (cur.events != EVENT_MAX) begin
                                upd.events = cur.events + 1'b1;
                            end
                            upd.seen = 1'b1;
                        end
                    end
                    default: st = ST_NORMAL;
                endcase
            end
        end else begin
            unique case (cur.status)
                ST_NORMAL: do_normal = 1'b1;
                ST_UNDER:  do_under  = 1'b1;
                ST_OVER:   do_over   = 1'b1;
                default:   st        = ST_NORMAL;
            endcase
        end

        if (do_normal) begin
            if (bel_trip) begin
                upd.above_cnt = '0;
                upd.under_cnt = under_inc;
                st = under_hit ? ST_UNDER : ST_NORMAL;
            end else if (!abv_trip) begin
                upd.under_cnt = '0;
                upd.above_cnt = '0;
                st = ST_NORMAL;
            end else begin
                upd.under_cnt = '0;
                upd.above_cnt = over_inc;
                st = over_hit ? ST_OVER : ST_NORMAL;
            end
        end
        if (do_under) begin
            if (bel_rec) begin
                upd.above_cnt = '0;
                st = ST_UNDER;
            end else if (!abv_rec) begin
                upd.under_cnt = '0;
                upd.above_cnt = '0;
                st = ST_NORMAL;
            end else begin
                upd.under_cnt = '0;
                upd.above_cnt = over_inc;
                st = over_hit ? ST_OVER : ST_UNDER;
            end
        end
        if (do_over) begin
            if (abv_rec) begin
                upd.under_cnt = '0;
                st = ST_OVER;
            end else if (!bel_rec) begin
                upd.under_cnt = '0;
                upd.above_cnt = '0;
                st = ST_NORMAL;
            end else begin
                upd.above_cnt = '0;
                upd.under_cnt = under_inc;
                st = under_hit ? ST_UNDER : ST_OVER;
            end
        end
        upd.status = st;
    end

    // result
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s1_adv) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_adv) begin
            if (s1_inrange_reg) begin
                m_data_reg <= {1'b0, lat, st, s1_chan_reg};
            end else begin
                m_data_reg <= {1'b0, 1'b0, ST_NORMAL, s1_chan_reg};
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

`ifndef NO_ASSERTIONS
    a_latch_is_over: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_data_reg[6] |-> m_data_reg[5:4] == ST_OVER)
        else $error("latched result without over status");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> m_data_reg[5:4] != 2'd3)
        else $error("result status out of range");

    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> s1_valid_reg && m_valid_reg && !m_tready)
        else $error("input stalled without a full output");

    a_fwd_needs_item: assert property (@(posedge aclk) disable iff (!aresetn)
        fwd_reg |-> s1_valid_reg)
        else $error("forwarding flag set with no item in update stage");

    a_write_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |-> s1_valid_reg && s1_inrange_reg && s1_adv)
        else $error("state write without a valid in-range item");
`endif

endmodule

`default_nettype wire
